// ----- design/tbfc_pkg.sv -----
`timescale 1ns / 1ps
package tbfc_pkg;

  typedef struct packed {
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } vtx_t;

  typedef enum logic [2:0] {
    SrcA = 3'd0,
    SrcB = 3'd1,
    SrcC = 3'd2,
    SrcX0 = 3'd3,
    SrcX1 = 3'd4
  } src_e;

  // one triangle job: vertices plus the emit list
  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic [1:0] xin;   // base vertex shared by both crossings
    logic [1:0] x0far; // far vertex of first crossing
    logic [1:0] x1far; // far vertex of second crossing
    logic signed [33:0] d_in;
    logic signed [33:0] d0far;
    logic signed [33:0] d1far;
    logic [2:0] cnt;
    src_e [5:0] seq;
  } job_t;

  localparam int unsigned QDepth = 2;

  localparam logic [1:0] RegAxis = 2'd0;
  localparam logic [1:0] RegNeg = 2'd1;
  localparam logic [1:0] RegHalf = 2'd2;

  function automatic vtx_t pick(input job_t j, input logic [1:0] k);
    vtx_t r;
    case (k)
      2'd0: r = j.a;
      2'd1: r = j.b;
      default: r = j.c;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] pickd(input logic signed [33:0] d0,
      input logic signed [33:0] d1, input logic signed [33:0] d2,
      input logic [1:0] k);
    logic signed [33:0] r;
    case (k)
      2'd0: r = d0;
      2'd1: r = d1;
      default: r = d2;
    endcase
    return r;
  endfunction

endpackage

// ----- design/tbfc_front.sv -----
`timescale 1ns / 1ps
module tbfc_front import tbfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  vtx_t        vtx_i,
  input  logic [1:0]  axis_i,
  input  logic        neg_i,
  input  logic [30:0] half_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  vtx_t held0_q, held1_q;
  logic [1:0] cnt_q, cnt_d;
  logic signed [33:0] d0, d1, d2;
  logic o0, o1, o2;
  job_t job;

  function automatic logic signed [33:0] plane_dist(input vtx_t v, input logic [1:0] ax,
      input logic ng, input logic [30:0] h);
    logic signed [33:0] c;
    case (ax)
      2'd0: c = 34'(v.px);
      2'd1: c = 34'(v.py);
      default: c = 34'(v.pz);
    endcase
    if (ng) c = -c;
    return c - $signed({3'b000, h});
  endfunction

  assign ready_o = (cnt_q != 2'd2) || job_ready_i;
  assign job_valid_o = valid_i && (cnt_q == 2'd2);

  always_comb begin
    d0 = plane_dist(held0_q, axis_i, neg_i, half_i);
    d1 = plane_dist(held1_q, axis_i, neg_i, half_i);
    d2 = plane_dist(vtx_i, axis_i, neg_i, half_i);
    o0 = d0 > 0;
    o1 = d1 > 0;
    o2 = d2 > 0;
    job = '0;
    job.a = held0_q;
    job.b = held1_q;
    job.c = vtx_i;
    job.seq = {6{SrcA}};
    case ({o2, o1, o0})
      3'b000: begin
        job.cnt = 3'd3;
        job.seq[0] = SrcA; job.seq[1] = SrcB; job.seq[2] = SrcC;
      end
      3'b001, 3'b100: begin
        job.cnt = 3'd6;
        job.xin = o0 ? 2'd0 : 2'd2;
        job.x0far = o0 ? 2'd1 : 2'd0;
        job.x1far = o0 ? 2'd2 : 2'd1;
        job.seq[0] = o0 ? SrcB : SrcA;
        job.seq[1] = o0 ? SrcC : SrcB;
        job.seq[2] = SrcX0; job.seq[3] = SrcX1; job.seq[4] = SrcX0;
        job.seq[5] = o0 ? SrcC : SrcB;
      end
      3'b010: begin
        job.cnt = 3'd6;
        job.xin = 2'd1; job.x0far = 2'd0; job.x1far = 2'd2;
        job.seq[0] = SrcX0; job.seq[1] = SrcC; job.seq[2] = SrcA;
        job.seq[3] = SrcC; job.seq[4] = SrcX0; job.seq[5] = SrcX1;
      end
      3'b110, 3'b101, 3'b011: begin
        job.cnt = 3'd3;
        job.xin = !o0 ? 2'd0 : (!o1 ? 2'd1 : 2'd2);
        job.x0far = !o0 ? 2'd1 : (!o1 ? 2'd2 : 2'd0);
        job.x1far = !o0 ? 2'd2 : (!o1 ? 2'd0 : 2'd1);
        job.seq[0] = !o0 ? SrcA : (!o1 ? SrcB : SrcC);
        job.seq[1] = SrcX0; job.seq[2] = SrcX1;
      end
      default: job.cnt = 3'd0;
    endcase
    job.d_in = pickd(d0, d1, d2, job.xin);
    job.d0far = pickd(d0, d1, d2, job.x0far);
    job.d1far = pickd(d0, d1, d2, job.x1far);
  end

  assign job_o = job;

  always_comb begin
    cnt_d = cnt_q;
    if (valid_i && ready_o) cnt_d = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o && cnt_q == 2'd0) held0_q <= vtx_i;
    if (valid_i && ready_o && cnt_q == 2'd1) held1_q <= vtx_i;
  end

endmodule

// ----- design/tbfc_queue.sv -----
`timescale 1ns / 1ps
module tbfc_queue import tbfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  job_t  data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output job_t  data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  job_t mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] fill_q;
  logic push, pop;

  assign ready_o = fill_q != (PtrW+1)'(QDepth);
  assign valid_o = fill_q != '0;
  assign data_o = mem_q[rd_q];
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- design/tbfc_back.sv -----
`timescale 1ns / 1ps
module tbfc_back import tbfc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   job_valid_i,
  output logic   job_ready_o,
  input  job_t   job_i,
  output logic   valid_o,
  input  logic   ready_i,
  output vtx_t   vtx_o,
  output logic   last_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StDiv  = 6'b000010,
    StMul  = 6'b000100,
    StAdd  = 6'b001000,
    StEmit = 6'b010000,
    StNext = 6'b100000
  } state_e;

  state_e st_q, st_d;
  job_t j_q;
  logic xsel_q;
  logic [2:0] idx_q;
  logic [2:0] fld_q;
  logic [5:0] bit_q;
  logic [33:0] den_q, rem_q;
  logic [30:0] lo_q;
  logic signed [32:0] s_q;
  vtx_t x0_q, x1_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] base_q;
  vtx_t out_q;
  logic last_q;
  logic out_v_q;

  vtx_t va, vb;
  logic signed [32:0] fa, fb, lerp_res;
  logic signed [34:0] rr;
  logic [35:0] trial;
  src_e cur;
  logic [33:0] ua, ub, den;
  logic [62:0] num;

  assign job_ready_o = (st_q == StIdle);
  assign valid_o = out_v_q;
  assign vtx_o = out_q;
  assign last_o = last_q;

  always_comb begin
    va = pick(j_q, j_q.xin);
    vb = pick(j_q, xsel_q ? j_q.x1far : j_q.x0far);
    case (fld_q)
      3'd0: begin fa = 33'(va.px); fb = 33'(vb.px); end
      3'd1: begin fa = 33'(va.py); fb = 33'(vb.py); end
      3'd2: begin fa = 33'(va.pz); fb = 33'(vb.pz); end
      3'd3: begin fa = 33'(va.nx); fb = 33'(vb.nx); end
      3'd4: begin fa = 33'(va.ny); fb = 33'(vb.ny); end
      default: begin fa = 33'(va.nz); fb = 33'(vb.nz); end
    endcase
    rr = 35'(base_q) + 35'((prod_q + 66'sd536870912) >>> 30);
    if (fld_q < 3'd3) begin
      if (rr > 35'sh07FFFFFFF) lerp_res = 33'sh07FFFFFFF;
      else if (rr < -35'sh080000000) lerp_res = -33'sh080000000;
      else lerp_res = rr[32:0];
    end else begin
      if (rr > 35'sd32767) lerp_res = 33'sd32767;
      else if (rr < -35'sd32768) lerp_res = -33'sd32768;
      else lerp_res = rr[32:0];
    end
    cur = j_q.seq[idx_q];
    ua = j_q.d_in[33] ? 34'(-j_q.d_in) : 34'(j_q.d_in);
    ub = xsel_q ? (j_q.d1far[33] ? 34'(-j_q.d1far) : 34'(j_q.d1far))
                : (j_q.d0far[33] ? 34'(-j_q.d0far) : 34'(j_q.d0far));
    den = ua + ub;
    num = {ua[32:0], 30'd0} + {30'd0, den[33:1]};
    trial = {1'b0, rem_q, lo_q[30]} - {2'b00, den_q};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (job_valid_i && job_i.cnt != 3'd0)
                st_d = (job_i.cnt == 3'd6 || job_i.seq[1] == SrcX0) ? StDiv : StEmit;
      StDiv:  if (bit_q == 6'd0) st_d = StMul;
      StMul:  st_d = StAdd;
      StAdd:  if (fld_q == 3'd5) st_d = xsel_q ? StEmit : StDiv;
              else st_d = StMul;
      StEmit: if (!out_v_q || ready_i) st_d = StNext;
      StNext: st_d = (idx_q == j_q.cnt - 3'd1) ? StIdle : StEmit;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StEmit && (!out_v_q || ready_i)) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        j_q <= job_i;
        xsel_q <= 1'b0;
        idx_q <= '0;
        bit_q <= 6'd32;
        rem_q <= '0;
        fld_q <= '0;
      end
      StDiv: begin
        if (bit_q == 6'd32) begin
          // quotient fits 31 bits, so the top dividend bits seed the remainder
          rem_q <= {2'b00, num[62:31]};
          lo_q <= num[30:0];
          den_q <= den;
          s_q <= '0;
          bit_q <= 6'd30;
        end else begin
          if (!trial[35]) begin
            rem_q <= trial[33:0];
            s_q <= {s_q[31:0], 1'b1};
          end else begin
            rem_q <= {rem_q[32:0], lo_q[30]};
            s_q <= {s_q[31:0], 1'b0};
          end
          lo_q <= {lo_q[29:0], 1'b0};
          bit_q <= bit_q - 6'd1;
        end
      end
      StMul: begin
        base_q <= fa;
        prod_q <= 66'(s_q) * 66'(fb - fa);
      end
      StAdd: begin
        case (fld_q)
          3'd0: if (xsel_q) x1_q.px <= lerp_res[31:0]; else x0_q.px <= lerp_res[31:0];
          3'd1: if (xsel_q) x1_q.py <= lerp_res[31:0]; else x0_q.py <= lerp_res[31:0];
          3'd2: if (xsel_q) x1_q.pz <= lerp_res[31:0]; else x0_q.pz <= lerp_res[31:0];
          3'd3: if (xsel_q) x1_q.nx <= lerp_res[15:0]; else x0_q.nx <= lerp_res[15:0];
          3'd4: if (xsel_q) x1_q.ny <= lerp_res[15:0]; else x0_q.ny <= lerp_res[15:0];
          default: if (xsel_q) x1_q.nz <= lerp_res[15:0]; else x0_q.nz <= lerp_res[15:0];
        endcase
        if (fld_q == 3'd5) begin
          xsel_q <= 1'b1;
          bit_q <= 6'd32;
          fld_q <= '0;
        end else begin
          fld_q <= fld_q + 3'd1;
        end
      end
      StEmit: begin
        if (!out_v_q || ready_i) begin
          case (cur)
            SrcA: out_q <= j_q.a;
            SrcB: out_q <= j_q.b;
            SrcC: out_q <= j_q.c;
            SrcX0: out_q <= x0_q;
            default: out_q <= x1_q;
          endcase
          last_q <= (idx_q == j_q.cnt - 3'd1);
        end
      end
      StNext: idx_q <= idx_q + 3'd1;
      default: ;
    endcase
  end

endmodule

// ----- design/triangle_box_face_clipper.sv -----
`timescale 1ns / 1ps
// A passing triangle's first vertex goes out through the job queue, the back end's Emit state
// and output register after its third vertex; a clipped one first runs, per crossing, a serial
// divide and a lerp of each field. Vertices 1 and 2 are accepted without stalling; each emitted
// vertex passes the Emit and Next states; a two-entry job queue lets the front hold the next triangle.
// Reset (rst_ni low, asynchronous) clears counters and queue; config registers take reset values.
module triangle_box_face_clipper import tbfc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [1:0] axis_q;
  logic neg_q;
  logic [30:0] half_q;
  vtx_t vin, vout;
  logic jv, jr, qv, qr;
  job_t jf, jb;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      neg_q <= 1'b0;
      half_q <= 31'd32768;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegAxis: axis_q <= pwdata[1:0];
        RegNeg: neg_q <= pwdata[0];
        RegHalf: half_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAxis: prdata = {30'd0, axis_q};
      RegNeg: prdata = {31'd0, neg_q};
      RegHalf: prdata = {1'b0, half_q};
      default: prdata = '0;
    endcase
  end

  assign vin.px = s_axis_tdata[31:0];
  assign vin.py = s_axis_tdata[63:32];
  assign vin.pz = s_axis_tdata[95:64];
  assign vin.nx = s_axis_tdata[111:96];
  assign vin.ny = s_axis_tdata[127:112];
  assign vin.nz = s_axis_tdata[143:128];
  assign m_axis_tdata = {vout.nz, vout.ny, vout.nx, vout.pz, vout.py, vout.px};

  tbfc_front u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .vtx_i(vin),
    .axis_i(axis_q), .neg_i(neg_q), .half_i(half_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(jf)
  );

  tbfc_queue u_queue (
    .clk_i, .rst_ni, .valid_i(jv), .ready_o(jr), .data_i(jf),
    .valid_o(qv), .ready_i(qr), .data_o(jb)
  );

  tbfc_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_ready_o(qr), .job_i(jb),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .vtx_o(vout),
    .last_o(m_axis_tlast)
  );

endmodule
